### rtl/core/cdq_pkg.sv
// shared constants, types and index helpers for the circular buffer deque
`default_nettype none

package cdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed widths of the stream fields
    localparam int OP_W       = 2;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int S_TUSER_W  = OP_W;
    localparam int S_TDATA_W  = VALUE_W;
    localparam int M_FIELDS_W = 3 * VALUE_W + COUNT_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic execute;   // update pointers, write or read the popped entry
        logic fetch;     // read the new front and back entries
        logic load;      // fill the output register
    } cdq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } cdq_sts_t;

    // (a + b) mod DEPTH for a, b below DEPTH
    function automatic idx_t idx_add(input idx_t a, input idx_t b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W + 1)'(DEPTH)) begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t idx_inc(input idx_t a);
        return (a == IDX_W'(DEPTH - 1)) ? '0 : a + IDX_W'(1);
    endfunction

    function automatic idx_t idx_dec(input idx_t a);
        return (a == '0) ? IDX_W'(DEPTH - 1) : a - IDX_W'(1);
    endfunction

    // sign-extend or truncate a stored word to the stream field width
    function automatic logic [VALUE_W-1:0] to_field(input word_t w);
        return VALUE_W'(signed'(w));
    endfunction

endpackage

`default_nettype wire

### rtl/core/cdq_ctrl.sv
// sequencing state machine for the circular buffer deque
`default_nettype none

module cdq_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire cdq_pkg::cdq_sts_t    sts,
    output cdq_pkg::cdq_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // hold until the previous result has left
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/cdq_dp.sv
// ring store, head and count registers and output register of the deque
`default_nettype none

module cdq_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire cdq_pkg::cdq_cmd_t              cmd,
    output cdq_pkg::cdq_sts_t                   sts,
    input  wire logic [cdq_pkg::OP_W-1:0]       in_opcode,
    input  wire logic [cdq_pkg::VALUE_W-1:0]    in_value,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [cdq_pkg::VALUE_W-1:0]         out_popped,
    output logic [cdq_pkg::VALUE_W-1:0]         out_front,
    output logic [cdq_pkg::VALUE_W-1:0]         out_back,
    output logic [cdq_pkg::COUNT_W-1:0]         out_count,
    output logic [cdq_pkg::STATUS_W-1:0]        out_status
);

    // ring store, one write and two registered read ports
    cdq_pkg::word_t mem [cdq_pkg::DEPTH];

    cdq_pkg::idx_t  head_reg, head_next;
    cdq_pkg::cnt_t  cnt_reg, cnt_next;
    logic           out_valid_reg, out_valid_next;

    logic [cdq_pkg::OP_W-1:0]     op_reg;
    cdq_pkg::word_t               val_reg;
    logic [cdq_pkg::STATUS_W-1:0] status_reg, status_next;
    cdq_pkg::word_t               rd_a_reg, rd_b_reg;
    logic [cdq_pkg::VALUE_W-1:0]  popped_reg;

    logic [cdq_pkg::VALUE_W-1:0]  popped_out_reg, front_out_reg, back_out_reg;
    logic [cdq_pkg::COUNT_W-1:0]  count_out_reg;
    logic [cdq_pkg::STATUS_W-1:0] status_out_reg;

    logic           is_push, is_full, is_empty;
    logic           wr_en;
    cdq_pkg::idx_t  wr_addr, pop_addr, back_addr, rd_addr_a;

    assign is_push  = (op_reg == cdq_pkg::OP_PUSH_FRONT) ||
                      (op_reg == cdq_pkg::OP_PUSH_BACK);
    assign is_full  = (cnt_reg == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign is_empty = (cnt_reg == '0);

    // back entry of the live range; meaningless when empty, never used then
    assign back_addr = cdq_pkg::idx_add(head_reg,
                                        cdq_pkg::IDX_W'(cnt_reg - cdq_pkg::CNT_W'(1)));

    always_comb begin
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = head_reg;
        pop_addr    = head_reg;
        if (cmd.execute) begin
            if (is_push) begin
                if (is_full) begin
                    status_next = cdq_pkg::STS_OVERFLOW;
                end else begin
                    status_next = cdq_pkg::STS_OK;
                    wr_en       = 1'b1;
                    cnt_next    = cnt_reg + cdq_pkg::CNT_W'(1);
                    if (op_reg == cdq_pkg::OP_PUSH_FRONT) begin
                        head_next = cdq_pkg::idx_dec(head_reg);
                        wr_addr   = cdq_pkg::idx_dec(head_reg);
                    end else begin
                        wr_addr = cdq_pkg::idx_add(head_reg, cdq_pkg::IDX_W'(cnt_reg));
                    end
                end
            end else begin
                if (is_empty) begin
                    status_next = cdq_pkg::STS_UNDERFLOW;
                end else begin
                    status_next = cdq_pkg::STS_OK;
                    cnt_next    = cnt_reg - cdq_pkg::CNT_W'(1);
                    if (op_reg == cdq_pkg::OP_POP_FRONT) begin
                        head_next = cdq_pkg::idx_inc(head_reg);
                    end else begin
                        pop_addr = back_addr;
                    end
                end
            end
        end
    end

    // port a reads the popped entry during execute, the front during fetch
    assign rd_addr_a = cmd.execute ? pop_addr : head_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= val_reg;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[back_addr];
    end

    assign sts.out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= in_opcode;
            val_reg <= cdq_pkg::DATA_WIDTH'(in_value);
        end
        status_reg <= status_next;
        if (cmd.fetch) begin
            // popped entry arrives from the execute-cycle read
            if (!is_push && (status_reg == cdq_pkg::STS_OK)) begin
                popped_reg <= cdq_pkg::to_field(rd_a_reg);
            end else begin
                popped_reg <= '0;
            end
        end
        if (cmd.load) begin
            popped_out_reg <= popped_reg;
            front_out_reg  <= is_empty ? '0 : cdq_pkg::to_field(rd_a_reg);
            back_out_reg   <= is_empty ? '0 : cdq_pkg::to_field(rd_b_reg);
            count_out_reg  <= cdq_pkg::COUNT_W'(cnt_reg);
            status_out_reg <= status_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_popped = popped_out_reg;
    assign out_front  = front_out_reg;
    assign out_back   = back_out_reg;
    assign out_count  = count_out_reg;
    assign out_status = status_out_reg;

endmodule

`default_nettype wire

### rtl/core/circular_buffer_deque_unit.sv
// top level of the circular buffer deque: stream ports, controller and datapath
`default_nettype none

// each item goes from acceptance to a valid result through accept,
// execute (pointer update and store write or popped-entry read), fetch of the
// new front and back entries from the two registered read ports, and load of
// the output register once the previous result has left; s_tready stays low
// until then, and a new item is accepted while that result waits on m_tready
// aresetn (synchronous, active low) empties the deque and drops any result;
// the ring store itself is not cleared

module circular_buffer_deque_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [cdq_pkg::S_TDATA_W-1:0]     s_tdata,  // value[31:0]
    input  wire logic [cdq_pkg::S_TUSER_W-1:0]     s_tuser,  // opcode[1:0]
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // popped_value[31:0], front_value[63:32], back_value[95:64],
    // count[100:96], status[102:101], zero pad[103]
    output logic [cdq_pkg::M_TDATA_W-1:0]          m_tdata
);

    cdq_pkg::cdq_cmd_t cmd;
    cdq_pkg::cdq_sts_t sts;

    logic [cdq_pkg::VALUE_W-1:0]  popped_value;
    logic [cdq_pkg::VALUE_W-1:0]  front_value;
    logic [cdq_pkg::VALUE_W-1:0]  back_value;
    logic [cdq_pkg::COUNT_W-1:0]  count;
    logic [cdq_pkg::STATUS_W-1:0] status;

    // sequencer: accept, execute, fetch, load
    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ring store, head and count, output register
    cdq_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (s_tuser),
        .in_value   (s_tdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_popped (popped_value),
        .out_front  (front_value),
        .out_back   (back_value),
        .out_count  (count),
        .out_status (status)
    );

    // pack result fields from the lowest bit up, zero pad to whole bytes
    assign m_tdata = cdq_pkg::M_TDATA_W'({status, count, back_value,
                                          front_value, popped_value});

endmodule

`default_nettype wire
